// File: src/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types and constants of the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 16;

  localparam int REQ_W  = 12;
  localparam int OFF_W  = 12;
  localparam int STAT_W = 2;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_A_PRIME,
    S_A_SCAN,
    S_A_SPLIT,
    S_F_CHECK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    load;
    logic    clr;
    logic    rd_first;
    logic    prime;
    logic    scan;
    logic    wr_used;
    logic    wr_split;
    logic    rd_head;
    logic    wr_free;
    logic    res_load;
    status_e res_status;
    logic    res_off;
    logic    push;
  } ctrl_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic size_zero;
    logic heap_empty;
    logic off_bad;
    logic hit;
    logic fit;
    logic last;
    logic split;
    logic head_hdr;
    logic out_free;
  } stat_t;

endpackage

// File: src/ffha_req_if.sv
// ----------------------------------------------------------------------------
// ffha_req_if
// request channel: allocate or free command word
// ----------------------------------------------------------------------------
interface ffha_req_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [ffha_pkg::REQ_W-1:0]  req_bytes;
  logic [ffha_pkg::OFF_W-1:0]  block_offset;

  modport source (output valid, cmd, req_bytes, block_offset, input ready);
  modport sink   (input valid, cmd, req_bytes, block_offset, output ready);
endinterface

// File: src/ffha_rsp_if.sv
// ----------------------------------------------------------------------------
// ffha_rsp_if
// response channel: status and user offset word
// ----------------------------------------------------------------------------
interface ffha_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ffha_pkg::STAT_W-1:0]  status;
  logic [ffha_pkg::OFF_W-1:0]   user_offset;

  modport source (output valid, status, user_offset, input ready);
  modport sink   (input valid, status, user_offset, output ready);
endinterface

// File: src/ffha_dp.sv
// ----------------------------------------------------------------------------
// ffha_dp
// allocator datapath: granule map memory, header walk registers, result regs
// ----------------------------------------------------------------------------
module ffha_dp #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ffha_pkg::ctrl_t              ctrl_i,
  output ffha_pkg::stat_t              stat_o,
  input  logic                         in_cmd_i,
  input  logic [ffha_pkg::REQ_W-1:0]   in_req_bytes_i,
  input  logic [ffha_pkg::OFF_W-1:0]   in_block_offset_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ffha_pkg::STAT_W-1:0]  out_status_o,
  output logic [ffha_pkg::OFF_W-1:0]   out_user_offset_o
);

  localparam int GRANULES = HEAP_BYTES / 8;
  localparam int HDR_G    = (HEADER_BYTES + 7) / 8;
  localparam int LAST_HDR = GRANULES - HDR_G;
  localparam int HB       = HDR_G * 8;
  localparam int GW       = $clog2(GRANULES);
  localparam int CW       = (GW > 11) ? GW : 11;
  localparam int OW       = (GW + 4 > 12) ? GW + 4 : 12;
  localparam int HW       = (GW > 9) ? GW : 9;
  localparam int RW       = ffha_pkg::REQ_W;
  localparam int FW       = ffha_pkg::OFF_W;
  localparam int HDR_BIT  = 1;
  localparam int USED_BIT = 0;

  // map entry: header bit and used bit per granule
  logic [1:0]    mem_q [GRANULES];
  logic [1:0]    rdata_q;
  logic          we;
  logic [GW-1:0] wa;
  logic [1:0]    wd;
  logic [GW-1:0] ra;

  logic          req_cmd_q;
  logic [RW-1:0] req_bytes_q;
  logic [FW-1:0] req_off_q;

  logic [GW-1:0] clr_cnt_q, clr_cnt_d;
  logic [GW-1:0] cur_q, cur_d;
  logic          cur_used_q, cur_used_d;
  logic [GW-1:0] idx_q, idx_d;

  ffha_pkg::status_e res_status_q;
  logic [FW-1:0]     res_off_q;
  logic              out_valid_q, out_valid_d;
  ffha_pkg::status_e out_status_q;
  logic [FW-1:0]     out_off_q;

  logic [RW:0]   bytes_rnd;
  logic [CW-1:0] need;
  logic [CW-1:0] diff;
  logic [CW-1:0] split_at;
  logic [OW-1:0] user_off;
  logic [FW-1:0] off_sub;
  logic [HW-1:0] head_x;
  logic [GW-1:0] head;
  logic          hit, fit, last;

  // request decode
  assign bytes_rnd = {1'b0, req_bytes_q} + (RW + 1)'(7);
  assign need      = CW'(bytes_rnd[RW:3]) + CW'(HDR_G);
  assign diff      = CW'(idx_q - cur_q);
  assign split_at  = CW'(cur_q) + need;
  assign user_off  = (OW'(cur_q) << 3) + OW'(HB);
  assign off_sub   = req_off_q - FW'(HB);
  assign head_x    = HW'(off_sub[FW-1:3]);
  assign head      = head_x[GW-1:0];

  assign last = (idx_q == GW'(LAST_HDR));
  assign hit  = last || rdata_q[HDR_BIT];
  assign fit  = !cur_used_q && (diff >= need);

  always_comb begin
    stat_o            = '0;
    stat_o.clr_done   = (clr_cnt_q == GW'(GRANULES - 1));
    stat_o.is_free    = (req_cmd_q == ffha_pkg::CMD_FREE);
    stat_o.size_zero  = (req_bytes_q == '0);
    stat_o.heap_empty = (LAST_HDR == 0);
    stat_o.off_bad    = (req_off_q < FW'(HB)) || (req_off_q[2:0] != 3'd0) ||
                        (head_x >= HW'(LAST_HDR));
    stat_o.hit        = hit;
    stat_o.fit        = fit;
    stat_o.last       = last;
    stat_o.split      = (diff > need);
    stat_o.head_hdr   = rdata_q[HDR_BIT];
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // memory port selection
  always_comb begin
    we = 1'b0;
    wa = clr_cnt_q;
    wd = 2'b00;
    if (ctrl_i.clr) begin
      we = 1'b1;
      wa = clr_cnt_q;
      wd[HDR_BIT] = (clr_cnt_q == '0) || (clr_cnt_q == GW'(LAST_HDR));
    end else if (ctrl_i.wr_used) begin
      we = 1'b1;
      wa = cur_q;
      wd = 2'b11;
    end else if (ctrl_i.wr_split) begin
      we = 1'b1;
      wa = split_at[GW-1:0];
      wd = 2'b10;
    end else if (ctrl_i.wr_free) begin
      we = 1'b1;
      wa = head;
      wd[HDR_BIT] = (head == '0);
    end
  end

  always_comb begin
    ra = '0;
    if (ctrl_i.rd_first) begin
      ra = '0;
    end else if (ctrl_i.prime) begin
      ra = GW'(1);
    end else if (ctrl_i.scan) begin
      ra = idx_q + GW'(1);
    end else if (ctrl_i.rd_head) begin
      ra = head;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rdata_q <= mem_q[ra];
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      req_cmd_q   <= in_cmd_i;
      req_bytes_q <= in_req_bytes_i;
      req_off_q   <= in_block_offset_i;
    end
  end

  // header walk
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    cur_d      = cur_q;
    cur_used_d = cur_used_q;
    idx_d      = idx_q;
    if (ctrl_i.clr) begin
      clr_cnt_d = clr_cnt_q + GW'(1);
    end
    if (ctrl_i.prime) begin
      cur_d      = '0;
      cur_used_d = rdata_q[USED_BIT];
      idx_d      = GW'(1);
    end else if (ctrl_i.scan && !(hit && fit)) begin
      idx_d = idx_q + GW'(1);
      if (hit) begin
        cur_d      = idx_q;
        cur_used_d = rdata_q[USED_BIT];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      cur_q      <= '0;
      cur_used_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      cur_q      <= cur_d;
      cur_used_q <= cur_used_d;
      idx_q      <= idx_d;
    end
  end

  // pending result and output word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) begin
      res_status_q <= ctrl_i.res_status;
      res_off_q    <= ctrl_i.res_off ? user_off[FW-1:0] : '0;
    end
    if (ctrl_i.push) begin
      out_status_q <= res_status_q;
      out_off_q    <= res_off_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_i.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_status_q;
  assign out_user_offset_o = out_off_q;

endmodule

// File: src/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// allocator controller: map clearing, header walk and free sequencing
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ffha_pkg::stat_t  stat_i,
  output ffha_pkg::ctrl_t  ctrl_o
);

  ffha_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffha_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ffha_pkg::S_CLEAR: begin
        if (stat_i.clr_done) begin
          state_d = ffha_pkg::S_IDLE;
        end
      end
      ffha_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = ffha_pkg::S_DECODE;
        end
      end
      ffha_pkg::S_DECODE: begin
        if (stat_i.is_free) begin
          state_d = stat_i.off_bad ? ffha_pkg::S_DONE : ffha_pkg::S_F_CHECK;
        end else if (stat_i.size_zero || stat_i.heap_empty) begin
          state_d = ffha_pkg::S_DONE;
        end else begin
          state_d = ffha_pkg::S_A_PRIME;
        end
      end
      ffha_pkg::S_A_PRIME: begin
        state_d = ffha_pkg::S_A_SCAN;
      end
      ffha_pkg::S_A_SCAN: begin
        if (stat_i.hit && stat_i.fit) begin
          state_d = stat_i.split ? ffha_pkg::S_A_SPLIT : ffha_pkg::S_DONE;
        end else if (stat_i.last) begin
          state_d = ffha_pkg::S_DONE;
        end
      end
      ffha_pkg::S_A_SPLIT: begin
        state_d = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_F_CHECK: begin
        state_d = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          state_d = ffha_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ffha_pkg::S_CLEAR;
      end
    endcase
  end

  always_comb begin
    ctrl_o            = '0;
    ctrl_o.res_status = ffha_pkg::ST_OK;
    in_ready_o        = 1'b0;
    case (state_q)
      ffha_pkg::S_CLEAR: begin
        ctrl_o.clr = 1'b1;
      end
      ffha_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      ffha_pkg::S_DECODE: begin
        if (stat_i.is_free) begin
          if (stat_i.off_bad) begin
            ctrl_o.res_load   = 1'b1;
            ctrl_o.res_status = ffha_pkg::ST_BAD;
          end else begin
            ctrl_o.rd_head = 1'b1;
          end
        end else if (stat_i.size_zero) begin
          ctrl_o.res_load   = 1'b1;
          ctrl_o.res_status = ffha_pkg::ST_BAD;
        end else if (stat_i.heap_empty) begin
          ctrl_o.res_load   = 1'b1;
          ctrl_o.res_status = ffha_pkg::ST_NO_SPACE;
        end else begin
          ctrl_o.rd_first = 1'b1;
        end
      end
      ffha_pkg::S_A_PRIME: begin
        ctrl_o.prime = 1'b1;
      end
      ffha_pkg::S_A_SCAN: begin
        ctrl_o.scan = 1'b1;
        if (stat_i.hit && stat_i.fit) begin
          ctrl_o.wr_used    = 1'b1;
          ctrl_o.res_load   = 1'b1;
          ctrl_o.res_status = ffha_pkg::ST_OK;
          ctrl_o.res_off    = 1'b1;
        end else if (stat_i.last) begin
          ctrl_o.res_load   = 1'b1;
          ctrl_o.res_status = ffha_pkg::ST_NO_SPACE;
        end
      end
      ffha_pkg::S_A_SPLIT: begin
        ctrl_o.wr_split = 1'b1;
      end
      ffha_pkg::S_F_CHECK: begin
        ctrl_o.res_load = 1'b1;
        if (stat_i.head_hdr) begin
          ctrl_o.wr_free    = 1'b1;
          ctrl_o.res_status = ffha_pkg::ST_OK;
        end else begin
          ctrl_o.res_status = ffha_pkg::ST_BAD;
        end
      end
      ffha_pkg::S_DONE: begin
        ctrl_o.push = stat_i.out_free;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

endmodule

// File: src/first_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// first-fit allocator over a heap of 8-byte granules with block headers
// ----------------------------------------------------------------------------
// After reset every entry of the granule map is cleared, one entry per cycle,
// before the first word is taken. One request is worked on at a time. An
// allocate walks the granule map from the first header, one granule per cycle
// through the map memory's single read port, and stops at the first fitting
// block or at the last header. A new request is taken while the previous
// response word still sits in the output register.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffha_req_if.sink    req_i,
  ffha_rsp_if.source  rsp_o
);

  ffha_pkg::ctrl_t ctrl;
  ffha_pkg::stat_t stat;

  ffha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .stat_o            (stat),
    .in_cmd_i          (req_i.cmd),
    .in_req_bytes_i    (req_i.req_bytes),
    .in_block_offset_i (req_i.block_offset),
    .out_valid_o       (rsp_o.valid),
    .out_ready_i       (rsp_o.ready),
    .out_status_o      (rsp_o.status),
    .out_user_offset_o (rsp_o.user_offset)
  );

endmodule
